@@ rtl/zoned_log_bucket_mapper_core_assert.svh @@
// Assertion macros for the zoned log bucket mapper core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef ZONED_LOG_BUCKET_MAPPER_CORE_ASSERT_SVH
`define ZONED_LOG_BUCKET_MAPPER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZLBM_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ZLBM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/zlbm_pkg.sv @@
// Shared types, codes and constants of the zoned log bucket mapper.
// No dependencies; the CSR, MAC and core RTL files import this package.
package zlbm_pkg;

   localparam int DEF_MAX_BUCKETS        = 65536;
   localparam int DEF_MAX_ZONES          = 1024;
   localparam int DEF_MAX_SLOTS_PER_ZONE = 256;

   localparam int ADDR_W     = 48;
   localparam int MUL_A_W    = 32;
   localparam int MUL_B_W    = 16;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int BUCKET_W   = 16;
   localparam int SCAN_W     = 17;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_ERASE = 2'd2,
      CMD_SCAN  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_UNMAPPED     = 2'd1,
      ST_FULL         = 2'd2,
      ST_WRITE_FAILED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_ZONE_COUNT      = 3'd0,
      REG_SLOTS_PER_ZONE  = 3'd1,
      REG_BUCKET_BYTES    = 3'd2,
      REG_ZONE_STRIDE     = 3'd3,
      REG_BASE_OFFSET     = 3'd4,
      REG_BUCKET_COUNT    = 3'd5,
      REG_CLEAN_THRESHOLD = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic [10:0] zone_count;
      logic [8:0]  slots_per_zone;
      logic [20:0] bucket_bytes;
      logic [31:0] zone_stride_bytes;
      logic [39:0] base_offset;
      logic [16:0] bucket_count;
      logic [8:0]  clean_threshold;
   } cfg_type;

   // Ring geometry writes that the pointer logic must react to.
   typedef struct packed {
      logic        zc_wr;
      logic [10:0] zc_new;
      logic        spz_wr;
      logic [8:0]  spz_new;
   } cfg_evt_type;

   typedef struct packed {
      logic mul_en;
      logic add_en;
      logic add_init;
   } mac_ctrl_type;

   typedef struct packed {
      status_type          status;
      logic                zone_reset;
      logic                zone_finish;
      logic                loc_en;
      logic                zbase_en;
      logic                scan_found;
      logic [BUCKET_W-1:0] scan_bucket;
   } rsp_flags_type;

endpackage

@@ rtl/zlbm_map_ram.sv @@
// Bucket map storage: one write port and one read port with registered read data.
// Depends on nothing but its parameters.
module zlbm_map_ram #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 19,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/zlbm_mac.sv @@
// Shared multiply-accumulate unit: a registered 32x16 product and a 48-bit accumulator.
// Depends on zlbm_pkg for widths and the control struct.
module zlbm_mac import zlbm_pkg::*; (
   input  logic               clock,
   input  mac_ctrl_type       ctrl,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   input  logic [ADDR_W-1:0]  init,
   output logic [ADDR_W-1:0]  prod,
   output logic [ADDR_W-1:0]  acc
);

   logic [ADDR_W-1:0] prod_ff, prod_in;
   logic [ADDR_W-1:0] acc_ff, acc_in;

   always_comb begin
      prod_in = ctrl.mul_en ? ADDR_W'(a) * ADDR_W'(b) : prod_ff;
      acc_in  = acc_ff;
      if (ctrl.add_en) begin
         acc_in = (ctrl.add_init ? init : acc_ff) + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

@@ rtl/zlbm_csr.sv @@
// Configuration register file behind the APB-style port, with range saturation.
// Depends on zlbm_pkg for the register struct and index codes.
module zlbm_csr import zlbm_pkg::*; #(
   parameter int MAX_BUCKETS        = DEF_MAX_BUCKETS,
   parameter int MAX_ZONES          = DEF_MAX_ZONES,
   parameter int MAX_SLOTS_PER_ZONE = DEF_MAX_SLOTS_PER_ZONE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg,
   output cfg_evt_type           evt
);

   localparam int ZC_RST  = (MAX_ZONES < 1024) ? MAX_ZONES : 1024;
   localparam int SPZ_RST = (MAX_SLOTS_PER_ZONE < 256) ? MAX_SLOTS_PER_ZONE : 256;
   localparam int BC_RST  = (MAX_BUCKETS < 65536) ? MAX_BUCKETS : 65536;
   localparam cfg_type CFG_RST = '{
      zone_count:        11'(ZC_RST),
      slots_per_zone:    9'(SPZ_RST),
      bucket_bytes:      21'd4096,
      zone_stride_bytes: 32'd1048576,
      base_offset:       40'd0,
      bucket_count:      17'(BC_RST),
      clean_threshold:   9'd26
   };

   cfg_type     cfg_ff, cfg_in;
   logic        wr;
   reg_idx_type idx;
   logic [10:0] zc_sat;
   logic [8:0]  spz_sat;
   logic [16:0] bc_sat;

   assign wr     = psel & penable & pwrite;
   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:3]);
   assign pready = 1'b1;

   always_comb begin
      zc_sat = pwdata[10:0];
      if (zc_sat < 11'd2) begin
         zc_sat = 11'd2;
      end else if (32'(zc_sat) > MAX_ZONES) begin
         zc_sat = 11'(MAX_ZONES);
      end
      spz_sat = pwdata[8:0];
      if (spz_sat < 9'd1) begin
         spz_sat = 9'd1;
      end else if (32'(spz_sat) > MAX_SLOTS_PER_ZONE) begin
         spz_sat = 9'(MAX_SLOTS_PER_ZONE);
      end
      bc_sat = pwdata[16:0];
      if (32'(bc_sat) > MAX_BUCKETS) begin
         bc_sat = 17'(MAX_BUCKETS);
      end
   end

   always_comb begin
      cfg_in      = cfg_ff;
      evt         = '0;
      evt.zc_new  = zc_sat;
      evt.spz_new = spz_sat;
      if (wr) begin
         case (idx)
            REG_ZONE_COUNT: begin
               cfg_in.zone_count = zc_sat;
               evt.zc_wr = 1'b1;
            end
            REG_SLOTS_PER_ZONE: begin
               cfg_in.slots_per_zone = spz_sat;
               evt.spz_wr = 1'b1;
            end
            REG_BUCKET_BYTES:    cfg_in.bucket_bytes      = pwdata[20:0];
            REG_ZONE_STRIDE:     cfg_in.zone_stride_bytes = pwdata[31:0];
            REG_BASE_OFFSET:     cfg_in.base_offset       = pwdata[39:0];
            REG_BUCKET_COUNT:    cfg_in.bucket_count      = bc_sat;
            REG_CLEAN_THRESHOLD: cfg_in.clean_threshold   = pwdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_ZONE_COUNT:      prdata = CSR_DATA_W'(cfg_ff.zone_count);
         REG_SLOTS_PER_ZONE:  prdata = CSR_DATA_W'(cfg_ff.slots_per_zone);
         REG_BUCKET_BYTES:    prdata = CSR_DATA_W'(cfg_ff.bucket_bytes);
         REG_ZONE_STRIDE:     prdata = CSR_DATA_W'(cfg_ff.zone_stride_bytes);
         REG_BASE_OFFSET:     prdata = CSR_DATA_W'(cfg_ff.base_offset);
         REG_BUCKET_COUNT:    prdata = CSR_DATA_W'(cfg_ff.bucket_count);
         REG_CLEAN_THRESHOLD: prdata = CSR_DATA_W'(cfg_ff.clean_threshold);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/zoned_log_bucket_mapper_core.sv @@
// Flow: a read first looks up the map and a scan first walks the map entries; then every
// command passes the zone multiply, zone add, slot add and done states before its result.
// One command at a time, set by the shared multiply-accumulate unit
// doing zone base, slot offset and clean threshold one after another.
// Reset: synchronous; afterwards busy stays high while all MAX_BUCKETS map entries
// are swept clear one entry per cycle. The receiver cannot stall results.
`include "zoned_log_bucket_mapper_core_assert.svh"

module zoned_log_bucket_mapper_core import zlbm_pkg::*; #(
   parameter int MAX_BUCKETS        = DEF_MAX_BUCKETS,
   parameter int MAX_ZONES          = DEF_MAX_ZONES,
   parameter int MAX_SLOTS_PER_ZONE = DEF_MAX_SLOTS_PER_ZONE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_command,
   input  logic [BUCKET_W-1:0]   req_bucket_id,
   input  logic                  req_write_ok,
   input  logic                  req_scan_after,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [ADDR_W-1:0]     rsp_location,
   output logic                  rsp_zone_reset,
   output logic                  rsp_zone_finish,
   output logic [ADDR_W-1:0]     rsp_zone_base,
   output logic                  rsp_should_clean,
   output logic                  rsp_scan_found,
   output logic [BUCKET_W-1:0]   rsp_scan_bucket,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int BW      = $clog2(MAX_BUCKETS);
   localparam int ZW      = $clog2(MAX_ZONES);
   localparam int SW      = (MAX_SLOTS_PER_ZONE > 1) ? $clog2(MAX_SLOTS_PER_ZONE) : 1;
   localparam int MW      = 1 + ZW + SW;
   localparam int ZC_RST  = (MAX_ZONES < 1024) ? MAX_ZONES : 1024;

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_LOOKUP = 8'b0000_0100,
      S_SCAN   = 8'b0000_1000,
      S_ZMUL   = 8'b0001_0000,
      S_ZADD   = 8'b0010_0000,
      S_SADD   = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [ZW-1:0] wz_ff, wz_in;
   logic [SW-1:0] ws_ff, ws_in;
   logic [ZW-1:0] ez_ff, ez_in;
   logic [BW-1:0] clr_idx_ff, clr_idx_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [ZW-1:0]       op_zone_ff, op_zone_in;
   logic [SW-1:0]       op_slot_ff, op_slot_in;
   rsp_flags_type       res_ff, res_in;
   logic [ADDR_W-1:0]   zbase_ff, zbase_in;
   logic [SCAN_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [SCAN_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_location_ff, rsp_location_in;
   logic                rsp_zone_reset_ff, rsp_zone_reset_in;
   logic                rsp_zone_finish_ff, rsp_zone_finish_in;
   logic [ADDR_W-1:0]   rsp_zone_base_ff, rsp_zone_base_in;
   logic                rsp_should_clean_ff, rsp_should_clean_in;
   logic                rsp_scan_found_ff, rsp_scan_found_in;
   logic [BUCKET_W-1:0] rsp_scan_bucket_ff, rsp_scan_bucket_in;

   cfg_type      cfg;
   cfg_evt_type  cfg_evt;
   mac_ctrl_type mac_ctrl;
   logic [MUL_A_W-1:0] mac_a;
   logic [MUL_B_W-1:0] mac_b;
   logic [ADDR_W-1:0]  mac_prod;
   logic [ADDR_W-1:0]  mac_acc;

   logic          mem_we;
   logic [BW-1:0] mem_waddr;
   logic [MW-1:0] mem_wdata;
   logic [BW-1:0] mem_raddr;
   logic [MW-1:0] mem_rdata;
   logic          rd_valid;
   logic [ZW-1:0] rd_zone;
   logic [SW-1:0] rd_slot;

   logic              in_range;
   logic [ZW-1:0]     wz_next;
   logic [ZW-1:0]     ez_next;
   logic [SCAN_W-1:0] slot_next;
   logic [SCAN_W-1:0] free_zones;
   logic              clean_due;

   function automatic logic [ZW-1:0] next_zone(input logic [ZW-1:0] z, input logic [10:0] zc);
      logic [SCAN_W-1:0] inc;
      inc = SCAN_W'(z) + SCAN_W'(1);
      return (inc >= SCAN_W'(zc)) ? '0 : ZW'(inc);
   endfunction

   zlbm_csr #(
      .MAX_BUCKETS       (MAX_BUCKETS),
      .MAX_ZONES         (MAX_ZONES),
      .MAX_SLOTS_PER_ZONE(MAX_SLOTS_PER_ZONE)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg),
      .evt    (cfg_evt)
   );

   zlbm_mac u_mac (
      .clock(clock),
      .ctrl (mac_ctrl),
      .a    (mac_a),
      .b    (mac_b),
      .init (ADDR_W'(cfg.base_offset)),
      .prod (mac_prod),
      .acc  (mac_acc)
   );

   zlbm_map_ram #(
      .DEPTH(MAX_BUCKETS),
      .WIDTH(MW),
      .AW   (BW)
   ) u_map (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   assign rd_valid = mem_rdata[MW-1];
   assign rd_zone  = mem_rdata[MW-2 -: ZW];
   assign rd_slot  = mem_rdata[SW-1:0];

   assign in_range = 32'(req_bucket_id) < MAX_BUCKETS;
   assign wz_next  = next_zone(wz_ff, cfg.zone_count);
   assign ez_next  = next_zone(ez_ff, cfg.zone_count);
   assign slot_next = req_write_ok ? SCAN_W'(ws_ff) + SCAN_W'(1)
                                   : SCAN_W'(cfg.slots_per_zone);

   // Free zones between the write pointer and the erase pointer around the ring.
   assign free_zones = (ez_ff >= wz_ff)
                     ? SCAN_W'(ez_ff) - SCAN_W'(wz_ff)
                     : SCAN_W'(ez_ff) + SCAN_W'(cfg.zone_count) - SCAN_W'(wz_ff);
   assign clean_due  = ADDR_W'({free_zones, 8'h00}) <= mac_prod;

   always_comb begin
      state_in    = state_ff;
      wz_in       = wz_ff;
      ws_in       = ws_ff;
      ez_in       = ez_ff;
      clr_idx_in  = clr_idx_ff;
      pend_in     = pend_ff;
      op_zone_in  = op_zone_ff;
      op_slot_in  = op_slot_ff;
      res_in      = res_ff;
      zbase_in    = zbase_ff;
      scan_idx_in = scan_idx_ff;
      pend_idx_in = pend_idx_ff;
      mem_we      = 1'b0;
      mem_waddr   = BW'(req_bucket_id);
      mem_wdata   = '0;
      mem_raddr   = BW'(req_bucket_id);
      mac_ctrl    = '0;
      mac_a       = '0;
      mac_b       = '0;

      rsp_valid_in        = 1'b0;
      rsp_status_in       = rsp_status_ff;
      rsp_location_in     = rsp_location_ff;
      rsp_zone_reset_in   = rsp_zone_reset_ff;
      rsp_zone_finish_in  = rsp_zone_finish_ff;
      rsp_zone_base_in    = rsp_zone_base_ff;
      rsp_should_clean_in = rsp_should_clean_ff;
      rsp_scan_found_in   = rsp_scan_found_ff;
      rsp_scan_bucket_in  = rsp_scan_bucket_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            clr_idx_in = clr_idx_ff + BW'(1);
            if (clr_idx_ff == BW'(MAX_BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               res_in     = '0;
               op_zone_in = '0;
               op_slot_in = '0;
               case (cmd_type'(req_command))
                  CMD_READ: begin
                     res_in.loc_en = in_range;
                     state_in = S_LOOKUP;
                  end
                  CMD_WRITE: begin
                     state_in = S_ZMUL;
                     if (!in_range) begin
                        res_in.status = ST_UNMAPPED;
                     end else if (wz_ff == ez_ff) begin
                        res_in.status = ST_FULL;
                     end else begin
                        op_zone_in        = wz_ff;
                        op_slot_in        = ws_ff;
                        res_in.loc_en     = 1'b1;
                        res_in.zbase_en   = 1'b1;
                        res_in.zone_reset = (ws_ff == '0);
                        mem_we            = 1'b1;
                        mem_wdata         = req_write_ok ? {1'b1, wz_ff, ws_ff} : '0;
                        if (!req_write_ok) begin
                           res_in.status = ST_WRITE_FAILED;
                        end
                        if (slot_next >= SCAN_W'(cfg.slots_per_zone)) begin
                           res_in.zone_finish = 1'b1;
                           wz_in = wz_next;
                           ws_in = '0;
                        end else begin
                           ws_in = SW'(slot_next);
                        end
                     end
                  end
                  CMD_ERASE: begin
                     op_zone_in        = ez_ff;
                     res_in.zbase_en   = 1'b1;
                     res_in.zone_reset = 1'b1;
                     ez_in    = ez_next;
                     state_in = S_ZMUL;
                  end
                  CMD_SCAN: begin
                     scan_idx_in = req_scan_after ? SCAN_W'(req_bucket_id) + SCAN_W'(1) : '0;
                     pend_in     = 1'b0;
                     state_in    = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOOKUP: begin
            res_in.loc_en = res_ff.loc_en & rd_valid;
            if (!(res_ff.loc_en & rd_valid)) begin
               res_in.status = ST_UNMAPPED;
            end
            op_zone_in = rd_zone;
            op_slot_in = rd_slot;
            state_in   = S_ZMUL;
         end
         S_SCAN: begin
            // One map read is issued per cycle; its data is checked in the next cycle.
            if (scan_idx_ff < cfg.bucket_count) begin
               mem_raddr   = BW'(scan_idx_ff);
               pend_in     = 1'b1;
               pend_idx_in = scan_idx_ff;
               scan_idx_in = scan_idx_ff + SCAN_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && rd_valid && (rd_zone == ez_ff)) begin
               res_in.scan_found  = 1'b1;
               res_in.scan_bucket = pend_idx_ff[BUCKET_W-1:0];
               res_in.loc_en      = 1'b1;
               op_zone_in = rd_zone;
               op_slot_in = rd_slot;
               pend_in    = 1'b0;
               state_in   = S_ZMUL;
            end else if (!pend_ff && !(scan_idx_ff < cfg.bucket_count)) begin
               state_in = S_ZMUL;
            end
         end
         S_ZMUL: begin
            mac_ctrl.mul_en = 1'b1;
            mac_a    = cfg.zone_stride_bytes;
            mac_b    = MUL_B_W'(op_zone_ff);
            state_in = S_ZADD;
         end
         S_ZADD: begin
            mac_ctrl.add_en   = 1'b1;
            mac_ctrl.add_init = 1'b1;
            mac_ctrl.mul_en   = 1'b1;
            mac_a    = MUL_A_W'(cfg.bucket_bytes);
            mac_b    = MUL_B_W'(op_slot_ff);
            state_in = S_SADD;
         end
         S_SADD: begin
            zbase_in        = mac_acc;
            mac_ctrl.add_en = 1'b1;
            mac_ctrl.mul_en = 1'b1;
            mac_a    = MUL_A_W'(cfg.clean_threshold);
            mac_b    = MUL_B_W'(cfg.zone_count);
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in        = 1'b1;
            rsp_status_in       = res_ff.status;
            rsp_location_in     = res_ff.loc_en ? mac_acc : '0;
            rsp_zone_reset_in   = res_ff.zone_reset;
            rsp_zone_finish_in  = res_ff.zone_finish;
            rsp_zone_base_in    = res_ff.zbase_en ? zbase_ff : '0;
            rsp_should_clean_in = clean_due;
            rsp_scan_found_in   = res_ff.scan_found;
            rsp_scan_bucket_in  = res_ff.scan_bucket;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Ring geometry changes pull the pointers back into range.
      if (cfg_evt.zc_wr) begin
         ez_in = ZW'(cfg_evt.zc_new - 11'd1);
         if (32'(wz_ff) >= 32'(cfg_evt.zc_new)) begin
            wz_in = '0;
            ws_in = '0;
         end
      end
      if (cfg_evt.spz_wr) begin
         if (32'(ws_ff) >= 32'(cfg_evt.spz_new)) begin
            ws_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         wz_ff        <= '0;
         ws_ff        <= '0;
         ez_ff        <= ZW'(ZC_RST - 1);
         clr_idx_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wz_ff        <= wz_in;
         ws_ff        <= ws_in;
         ez_ff        <= ez_in;
         clr_idx_ff   <= clr_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_zone_ff          <= op_zone_in;
      op_slot_ff          <= op_slot_in;
      res_ff              <= res_in;
      zbase_ff            <= zbase_in;
      scan_idx_ff         <= scan_idx_in;
      pend_idx_ff         <= pend_idx_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_location_ff     <= rsp_location_in;
      rsp_zone_reset_ff   <= rsp_zone_reset_in;
      rsp_zone_finish_ff  <= rsp_zone_finish_in;
      rsp_zone_base_ff    <= rsp_zone_base_in;
      rsp_should_clean_ff <= rsp_should_clean_in;
      rsp_scan_found_ff   <= rsp_scan_found_in;
      rsp_scan_bucket_ff  <= rsp_scan_bucket_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_location     = rsp_location_ff;
   assign rsp_zone_reset   = rsp_zone_reset_ff;
   assign rsp_zone_finish  = rsp_zone_finish_ff;
   assign rsp_zone_base    = rsp_zone_base_ff;
   assign rsp_should_clean = rsp_should_clean_ff;
   assign rsp_scan_found   = rsp_scan_found_ff;
   assign rsp_scan_bucket  = rsp_scan_bucket_ff;

   `ZLBM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted command left busy low")
   `ZLBM_ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == S_DONE, rsp_valid, "finished command gave no result")
   `ZLBM_ASSERT_NOW(a_wz_range, clock, reset, !busy, 32'(wz_ff) < 32'(cfg.zone_count), "write zone outside ring")
   `ZLBM_ASSERT_NOW(a_ez_range, clock, reset, !busy, 32'(ez_ff) < 32'(cfg.zone_count), "erase zone outside ring")

endmodule
